[hw/rtl/sitoda_pkg.sv]
package sitoda_pkg;

    localparam int unsigned CHAR_BITS  = 7;
    localparam int unsigned DIGIT_BITS = 4;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;

    // A BCD digit at or above this value overflows when doubled.
    localparam logic [DIGIT_BITS-1:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_BITS-1:0] BCD_ADJ_ADD   = 4'd3;

endpackage

[hw/rtl/signed_int_to_decimal_ascii_core.sv]
// Signed integer to decimal ASCII text.
//
// Input channel (s_valid / s_ready / s_value): one beat carries one signed
// two's-complement integer of VALUE_BITS bits. Result channel (m_valid /
// m_ready / m_character / m_last_char): one beat per ASCII character, most
// significant first. A negative number opens with '-'; zero gives a single
// '0'; leading zeros are dropped. The final character of a number carries
// m_last_char.
//
// Operation: after the input beat the magnitude is shifted into a BCD register
// one bit per cycle (shift-and-add-3). The BCD register is then shifted out
// one digit per cycle while the receiver does not stall, leading zeros
// included. DIGITS is the decimal width of the magnitude (10 at 32 bits) and
// sets the register's size; a negative number sends its sign before the digits.
// s_ready is high only between items; the next item may enter while the last
// character still waits in the output register.
// Reset (aresetn low, synchronous) returns to idle and drops any pending
// character. When the receiver stalls, the character is held in the output
// register and the digit shift-out pauses until the beat is taken.
module signed_int_to_decimal_ascii_core #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [VALUE_BITS-1:0]         s_value,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sitoda_pkg::CHAR_BITS-1:0]     m_character,
    output logic                                 m_last_char
);

    // Decimal digits for an unsigned VALUE_BITS-bit magnitude:
    // floor(VALUE_BITS * log10(2)) + 1, with log10(2) ~ 1233 / 4096.
    localparam int unsigned DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int unsigned BCD_W  = DIGITS * sitoda_pkg::DIGIT_BITS;
    localparam int unsigned BIT_CW = $clog2(VALUE_BITS);
    localparam int unsigned DIG_CW = $clog2(DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGS
    } state_t;

    state_t                            state_reg,   state_next;
    logic [VALUE_BITS-1:0]             bin_reg,     bin_next;
    logic [BCD_W-1:0]                  bcd_reg,     bcd_next;
    logic [BIT_CW-1:0]                 bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]                 dig_cnt_reg, dig_cnt_next;
    logic                              neg_reg,     neg_next;
    logic                              started_reg, started_next;
    logic                              m_valid_reg, m_valid_next;
    logic [sitoda_pkg::CHAR_BITS-1:0]  m_char_reg,  m_char_next;
    logic                              m_last_reg,  m_last_next;

    logic [VALUE_BITS-1:0]             raw;
    logic [BCD_W-1:0]                  bcd_adj;
    logic [sitoda_pkg::DIGIT_BITS-1:0] top_digit;
    logic                              out_free;

    assign raw       = s_value;
    assign top_digit = bcd_reg[BCD_W-1 -: sitoda_pkg::DIGIT_BITS];
    assign out_free  = !m_valid_reg || m_ready;

    // Add 3 to every BCD digit of 5 or more ahead of the doubling shift.
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[i*sitoda_pkg::DIGIT_BITS +: sitoda_pkg::DIGIT_BITS]
                    >= sitoda_pkg::BCD_ADJ_LIMIT) begin
                bcd_adj[i*sitoda_pkg::DIGIT_BITS +: sitoda_pkg::DIGIT_BITS] =
                    bcd_reg[i*sitoda_pkg::DIGIT_BITS +: sitoda_pkg::DIGIT_BITS]
                    + sitoda_pkg::BCD_ADJ_ADD;
            end else begin
                bcd_adj[i*sitoda_pkg::DIGIT_BITS +: sitoda_pkg::DIGIT_BITS] =
                    bcd_reg[i*sitoda_pkg::DIGIT_BITS +: sitoda_pkg::DIGIT_BITS];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // Form the magnitude; the most negative value stays exact
                    // as an unsigned VALUE_BITS-bit number.
                    neg_next     = raw[VALUE_BITS-1];
                    bin_next     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CW'(VALUE_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                // Advance one magnitude bit into the BCD register.
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                if (bit_cnt_reg == '0) begin
                    dig_cnt_next = DIG_CW'(DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_DIGS;
                end else begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_char_next  = sitoda_pkg::CHAR_MINUS;
                    m_last_next  = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = ST_DIGS;
                end
            end
            ST_DIGS: begin
                if (!started_reg && top_digit == '0 && dig_cnt_reg != '0) begin
                    // Drop a leading zero without a beat.
                    bcd_next     = {bcd_reg[BCD_W-sitoda_pkg::DIGIT_BITS-1:0],
                                    {sitoda_pkg::DIGIT_BITS{1'b0}}};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else if (out_free) begin
                    m_char_next  = sitoda_pkg::CHAR_ZERO
                                   + sitoda_pkg::CHAR_BITS'(top_digit);
                    m_last_next  = (dig_cnt_reg == '0);
                    m_valid_next = 1'b1;
                    started_next = 1'b1;
                    bcd_next     = {bcd_reg[BCD_W-sitoda_pkg::DIGIT_BITS-1:0],
                                    {sitoda_pkg::DIGIT_BITS{1'b0}}};
                    if (dig_cnt_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        started_reg <= started_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last_char = m_last_reg;

endmodule

[tb/signed_int_to_decimal_ascii_core_tb.sv]
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core_tb;

    localparam int unsigned VALUE_BITS      = 32;
    localparam int unsigned RANDOM_VALUES   = 286;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 120;
    localparam longint      CYCLE_LIMIT     = 1_000_000;

    // One character beat of the result channel.
    typedef struct packed {
        logic [sitoda_pkg::CHAR_BITS-1:0] character;
        logic                             last_char;
    } char_beat_t;

    // Holds the expected text of every accepted value and checks the
    // characters against it in arrival order.
    class decimal_text_scoreboard;
        char_beat_t expected_chars[$];
        int         mismatches;
        int         values_seen;
        int         negatives_seen;
        int         chars_checked;

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH at %0t: %s", $realtime, what);
            end
        endfunction

        // Work out the decimal text of an accepted value and queue it.
        function void note_value(logic signed [VALUE_BITS-1:0] value);
            logic [VALUE_BITS-1:0] magnitude;
            logic [3:0]            digit_buf[24];
            int                    digit_count;
            logic                  negative;

            negative    = value[VALUE_BITS-1];
            // The unsigned view of the negated value is exact, the most
            // negative value included.
            magnitude   = negative ? (~value + 1'b1) : value;
            digit_count = 0;
            do begin
                digit_buf[digit_count] = 4'(magnitude % 10);
                magnitude              = magnitude / 10;
                digit_count++;
            end while (magnitude != 0);

            values_seen++;
            if (negative) begin
                negatives_seen++;
                expected_chars.push_back('{character: sitoda_pkg::CHAR_MINUS,
                                           last_char: 1'b0});
            end
            for (int i = digit_count - 1; i >= 0; i--) begin
                expected_chars.push_back('{character: sitoda_pkg::CHAR_ZERO
                                                      + 7'(digit_buf[i]),
                                           last_char: (i == 0)});
            end
        endfunction

        // Compare one received character beat with the oldest expectation.
        function void check_char(logic [sitoda_pkg::CHAR_BITS-1:0] character,
                                 logic last_char);
            char_beat_t want;

            chars_checked++;
            if (expected_chars.size() == 0) begin
                flag_mismatch($sformatf("unexpected character %0d last %0b",
                                        character, last_char));
                return;
            end
            want = expected_chars.pop_front();
            if (character !== want.character) begin
                flag_mismatch($sformatf("character expected %0d got %0d",
                                        want.character, character));
            end
            if (last_char !== want.last_char) begin
                flag_mismatch($sformatf("last_char expected %0b got %0b (character %0d)",
                                        want.last_char, last_char, want.character));
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void check_drained();
            if (expected_chars.size() != 0) begin
                flag_mismatch($sformatf("%0d characters never arrived",
                                        expected_chars.size()));
            end
        endfunction
    endclass

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_valid  = 1'b0;
    logic                              s_ready;
    logic signed [VALUE_BITS-1:0]      s_value  = '0;
    logic                              m_valid;
    logic                              m_ready  = 1'b0;
    logic [sitoda_pkg::CHAR_BITS-1:0]  m_character;
    logic                              m_last_char;

    decimal_text_scoreboard text_board = new();

    // Set by the stimulus: free_run removes idling on both sides, hold_off_req
    // asks the receiver for one long stall.
    bit     free_run     = 1'b0;
    bit     hold_off_req = 1'b0;
    bit     hold_off_seen = 1'b0;
    longint cycle_count  = 0;

    signed_int_to_decimal_ascii_core #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort the run if it outlives any plausible correct run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still due",
                     cycle_count, text_board.pending());
            $display("status: fail");
            $finish;
        end
    end

    // Sample both channels at the edge; values seen here are the ones from
    // before the edge, so the order of processes in the step does not matter.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            text_board.note_value(s_value);
        end
        if (aresetn && m_valid && m_ready) begin
            text_board.check_char(m_character, m_last_char);
        end
    end

    // Idle length: mostly none, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int roll;

        roll = $urandom_range(99);
        if (free_run || roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(60, 10);
    endfunction

    // Receiver: stall at random, and once hold off for a long stretch so that
    // the block fills up and drops s_ready while values keep being offered.
    initial begin
        int gap;

        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req  = 1'b0;
                hold_off_seen = 1'b1;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Offer one value after an idle gap and hold it until the beat is taken.
    // With no gap, valid stays high and only the payload moves on.
    task automatic send_value(input logic signed [VALUE_BITS-1:0] value, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Random values: full-range words for bit coverage, values of a chosen
    // digit count, and values straddling powers of ten.
    function automatic logic signed [VALUE_BITS-1:0] random_value();
        longint lo;
        longint hi;
        longint magnitude;
        int     roll;
        int     digits;

        roll = $urandom_range(99);
        if (roll < 30) begin
            return $urandom();
        end
        digits = $urandom_range(10, 1);
        lo     = 1;
        repeat (digits - 1) lo = lo * 10;
        if (roll < 85) begin
            hi        = (lo * 10 - 1 > 64'sd2147483647) ? 64'sd2147483647 : lo * 10 - 1;
            magnitude = (digits == 1) ? $urandom_range(9) : $urandom_range(hi, lo);
        end else begin
            magnitude = lo - 1 + $urandom_range(2);
        end
        if ($urandom_range(1)) begin
            return VALUE_BITS'(-magnitude);
        end
        return VALUE_BITS'(magnitude);
    endfunction

    initial begin
        logic signed [VALUE_BITS-1:0] edge_values[$];

        edge_values = '{0, 1, -1, 7, -9, 9, 10, -10, 99, 100, -100, 12345, -54321,
                        999999999, -999999999, 1000000000, -1000000000,
                        32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
                        32'sh55555555, 32'shAAAAAAAA, 32'sh0000FFFF, 32'shFFFF0000};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, zero, sign handling and digit-count boundaries.
        foreach (edge_values[i]) begin
            send_value(edge_values[i], pick_gap());
        end

        // Random: a stretch with no idling, then a long receiver hold-off
        // while values keep coming.
        for (int i = 0; i < RANDOM_VALUES; i++) begin
            if (i == 60) begin
                free_run = 1'b1;
            end
            if (i == 110) begin
                free_run = 1'b0;
            end
            if (i == 180) begin
                hold_off_req = 1'b1;
            end
            send_value(random_value(), pick_gap());
        end
        s_valid <= 1'b0;

        // Drain: wait for every due character, then let the block settle.
        @(posedge aclk);
        while (text_board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        text_board.check_drained();

        $display("converted %0d values (%0d negative), checked %0d characters",
                 text_board.values_seen, text_board.negatives_seen,
                 text_board.chars_checked);
        $display("receiver hold-off of %0d cycles %s, %0d mismatches",
                 HOLD_OFF_CYCLES, hold_off_seen ? "done" : "not reached",
                 text_board.mismatches);
        if (text_board.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
